>>> hw/rtl/sbr_pkg.sv
// sbr_pkg: shared constants, types and helpers of the slot bitmap range reserver
// depends on nothing; used by the interfaces, the control unit and the top level

package sbr_pkg;

  localparam int NUM_WORDS  = 64;
  localparam int WORD_BITS  = 64;
  localparam int WORD_SHIFT = 6;
  localparam int WORD_AW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CAPACITY   = NUM_WORDS * WORD_BITS;

  localparam int SLOT_W   = 12;
  localparam int COUNT_W  = SLOT_W + 1;
  localparam int RATE_W   = 16;
  localparam int PRICE_W  = 28;
  localparam int PROD_W   = COUNT_W + RATE_W;
  localparam int STATUS_W = 2;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-1:0] REG_PRICE_ADDR = 3'd0;

  localparam logic ACT_RESERVE = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_OCCUPIED = 2'd2
  } status_e;

  typedef struct packed {
    logic                 we;
    logic [WORD_AW-1:0]   waddr;
    logic [WORD_BITS-1:0] wdata;
    logic                 re;
    logic [WORD_AW-1:0]   raddr;
  } ram_req_t;

  // bits of word w covered by the inclusive slot range [s, e]
  function automatic logic [WORD_BITS-1:0] word_mask(input logic [WORD_AW-1:0] w,
                                                     input logic [SLOT_W-1:0]  s,
                                                     input logic [SLOT_W-1:0]  e);
    logic [WORD_SHIFT-1:0] lo;
    logic [WORD_SHIFT-1:0] hi;
    logic [WORD_BITS-1:0]  ones;
    ones = '1;
    lo = (w == WORD_AW'(s >> WORD_SHIFT)) ? s[WORD_SHIFT-1:0] : '0;
    hi = (w == WORD_AW'(e >> WORD_SHIFT)) ? e[WORD_SHIFT-1:0] : '1;
    return (ones >> (WORD_SHIFT'(WORD_BITS - 1) - hi)) & (ones << lo);
  endfunction

endpackage

>>> hw/rtl/sbr_req_if.sv
// sbr_req_if: request channel (valid/ready) carrying action and slot range
// depends on sbr_pkg

interface sbr_req_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [sbr_pkg::SLOT_W-1:0]  start_slot;
  logic [sbr_pkg::SLOT_W-1:0]  end_slot;

  modport source (output valid, action, start_slot, end_slot, input ready);
  modport sink   (input valid, action, start_slot, end_slot, output ready);
endinterface

>>> hw/rtl/sbr_rsp_if.sv
// sbr_rsp_if: response channel (valid/ready) carrying status and price
// depends on sbr_pkg

interface sbr_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sbr_pkg::STATUS_W-1:0]  status;
  logic [sbr_pkg::PRICE_W-1:0]   price;

  modport source (output valid, status, price, input ready);
  modport sink   (input valid, status, price, output ready);
endinterface

>>> hw/rtl/sbr_ram.sv
// sbr_ram: generic synchronous ram, one write port and one read port
// read data registered, valid in the cycle after the read request; no dependencies

module sbr_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/sbr_cfg.sv
// sbr_cfg: apb register file holding the price per slot
// depends on sbr_pkg

module sbr_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sbr_pkg::APB_AW-1:0]    paddr,
  input  logic [sbr_pkg::APB_DW-1:0]    pwdata,
  output logic [sbr_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  output logic [sbr_pkg::RATE_W-1:0]    price_per_slot_o
);

  logic [sbr_pkg::RATE_W-1:0] price_q;
  logic                       wr_xfer;

  assign pready  = 1'b1;
  assign wr_xfer = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      price_q <= '0;
    end else if (wr_xfer && (paddr == sbr_pkg::REG_PRICE_ADDR)) begin
      price_q <= pwdata[sbr_pkg::RATE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == sbr_pkg::REG_PRICE_ADDR) begin
      prdata = sbr_pkg::APB_DW'(price_q);
    end
  end

  assign price_per_slot_o = price_q;

endmodule

>>> hw/rtl/sbr_ctrl.sv
// sbr_ctrl: sequencer for clear, check and read-modify-write passes over the bitmap
// depends on sbr_pkg, sbr_req_if, sbr_rsp_if; drives the bitmap ram

module sbr_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  sbr_req_if.sink                           req,
  sbr_rsp_if.source                         rsp,
  input  logic [sbr_pkg::RATE_W-1:0]        price_per_slot_i,
  output sbr_pkg::ram_req_t                 ram_req_o,
  input  logic [sbr_pkg::WORD_BITS-1:0]     ram_rdata_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_MODIFY,
    ST_PRICE,
    ST_DONE
  } state_e;

  state_e                              state_q;
  logic [sbr_pkg::WORD_AW-1:0]         clr_w_q;
  logic                                act_q;
  logic [sbr_pkg::SLOT_W-1:0]          s_q;
  logic [sbr_pkg::SLOT_W-1:0]          e_q;
  logic [sbr_pkg::WORD_AW-1:0]         rd_w_q;
  logic                                rd_more_q;
  logic                                ev_v_q;
  logic [sbr_pkg::WORD_AW-1:0]         ev_w_q;
  sbr_pkg::status_e                    status_q;
  logic [sbr_pkg::PRICE_W-1:0]         price_q;
  logic                                out_valid_q;
  sbr_pkg::status_e                    out_status_q;
  logic [sbr_pkg::PRICE_W-1:0]         out_price_q;

  logic [sbr_pkg::WORD_AW-1:0]         ws;
  logic [sbr_pkg::WORD_AW-1:0]         we;
  logic [sbr_pkg::WORD_AW-1:0]         in_ws;
  logic [sbr_pkg::WORD_BITS-1:0]       mask;
  logic                                hit;
  logic                                in_xfer;
  logic                                bad_range;
  logic                                pass_on;
  logic [sbr_pkg::COUNT_W-1:0]         count;
  logic [sbr_pkg::PROD_W-1:0]          prod;

  assign ws      = sbr_pkg::WORD_AW'(s_q >> sbr_pkg::WORD_SHIFT);
  assign we      = sbr_pkg::WORD_AW'(e_q >> sbr_pkg::WORD_SHIFT);
  assign in_ws   = sbr_pkg::WORD_AW'(req.start_slot >> sbr_pkg::WORD_SHIFT);
  assign mask    = sbr_pkg::word_mask(ev_w_q, s_q, e_q);
  assign hit     = |(ram_rdata_i & mask);
  assign pass_on = (state_q == ST_CHECK) || (state_q == ST_MODIFY);

  assign req.ready = (state_q == ST_IDLE);
  assign in_xfer   = req.valid && req.ready;
  assign bad_range = (req.end_slot < req.start_slot) ||
                     (32'(req.end_slot) >= sbr_pkg::CAPACITY);

  assign count = sbr_pkg::COUNT_W'(e_q) - sbr_pkg::COUNT_W'(s_q) + sbr_pkg::COUNT_W'(1);
  assign prod  = sbr_pkg::PROD_W'(count) * sbr_pkg::PROD_W'(price_per_slot_i);

  // ram access: clear pass, pass reads, write back behind the read stream
  always_comb begin
    ram_req_o.re    = pass_on && rd_more_q;
    ram_req_o.raddr = rd_w_q;
    ram_req_o.we    = (state_q == ST_CLEAR) || ((state_q == ST_MODIFY) && ev_v_q);
    ram_req_o.waddr = (state_q == ST_CLEAR) ? clr_w_q : ev_w_q;
    if (state_q == ST_CLEAR) begin
      ram_req_o.wdata = '0;
    end else if (act_q == sbr_pkg::ACT_RELEASE) begin
      ram_req_o.wdata = ram_rdata_i & ~mask;
    end else begin
      ram_req_o.wdata = ram_rdata_i | mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_w_q      <= '0;
      act_q        <= sbr_pkg::ACT_RESERVE;
      s_q          <= '0;
      e_q          <= '0;
      rd_w_q       <= '0;
      rd_more_q    <= 1'b0;
      ev_v_q       <= 1'b0;
      ev_w_q       <= '0;
      status_q     <= sbr_pkg::STATUS_DONE;
      price_q      <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= sbr_pkg::STATUS_DONE;
      out_price_q  <= '0;
    end else begin
      if ((state_q == ST_DONE) && (!out_valid_q || rsp.ready)) begin
        out_valid_q  <= 1'b1;
        out_status_q <= status_q;
        out_price_q  <= price_q;
      end else if (rsp.valid && rsp.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_w_q <= clr_w_q + sbr_pkg::WORD_AW'(1);
          if (clr_w_q == sbr_pkg::WORD_AW'(sbr_pkg::NUM_WORDS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            act_q  <= req.action;
            s_q    <= req.start_slot;
            e_q    <= req.end_slot;
            rd_w_q <= in_ws;
            ev_v_q <= 1'b0;
            if (bad_range) begin
              status_q  <= sbr_pkg::STATUS_INVALID;
              price_q   <= '0;
              rd_more_q <= 1'b0;
              state_q   <= ST_DONE;
            end else if (req.action == sbr_pkg::ACT_RELEASE) begin
              rd_more_q <= 1'b1;
              state_q   <= ST_MODIFY;
            end else begin
              rd_more_q <= 1'b1;
              state_q   <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          ev_w_q <= rd_w_q;
          if (ev_v_q && hit) begin
            status_q  <= sbr_pkg::STATUS_OCCUPIED;
            price_q   <= '0;
            rd_more_q <= 1'b0;
            ev_v_q    <= 1'b0;
            state_q   <= ST_DONE;
          end else if (ev_v_q && (ev_w_q == we)) begin
            rd_w_q    <= ws;
            rd_more_q <= 1'b1;
            ev_v_q    <= 1'b0;
            state_q   <= ST_MODIFY;
          end else begin
            ev_v_q    <= rd_more_q;
            rd_w_q    <= rd_w_q + sbr_pkg::WORD_AW'(1);
            rd_more_q <= rd_more_q && (rd_w_q != we);
          end
        end
        ST_MODIFY: begin
          ev_w_q <= rd_w_q;
          if (ev_v_q && (ev_w_q == we)) begin
            rd_more_q <= 1'b0;
            ev_v_q    <= 1'b0;
            if (act_q == sbr_pkg::ACT_RESERVE) begin
              state_q <= ST_PRICE;
            end else begin
              status_q <= sbr_pkg::STATUS_DONE;
              price_q  <= '0;
              state_q  <= ST_DONE;
            end
          end else begin
            ev_v_q    <= rd_more_q;
            rd_w_q    <= rd_w_q + sbr_pkg::WORD_AW'(1);
            rd_more_q <= rd_more_q && (rd_w_q != we);
          end
        end
        ST_PRICE: begin
          status_q <= sbr_pkg::STATUS_DONE;
          price_q  <= prod[sbr_pkg::PRICE_W-1:0];
          state_q  <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || rsp.ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid  = out_valid_q;
  assign rsp.status = out_status_q;
  assign rsp.price  = out_price_q;

  a_no_write_in_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) |-> !ram_req_o.we)
    else $error("bitmap written during occupancy check");

  a_inverted_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (req.end_slot < req.start_slot)) |=>
    ((state_q == ST_DONE) && (status_q == sbr_pkg::STATUS_INVALID)))
    else $error("inverted range not refused");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_req_o.we && (state_q == ST_MODIFY)) |-> ((ev_w_q >= ws) && (ev_w_q <= we)))
    else $error("write back outside the requested words");

  a_price_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != sbr_pkg::STATUS_DONE)) |-> (out_price_q == '0))
    else $error("nonzero price on a refused request");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !req.ready)
    else $error("request taken during clearing pass");

endmodule

>>> hw/rtl/slot_bitmap_range_reserver.sv
// slot_bitmap_range_reserver: top level, apb register file, control unit, bitmap ram
// depends on sbr_pkg, sbr_req_if, sbr_rsp_if, sbr_cfg, sbr_ctrl, sbr_ram
//
// usage
//   req_i carries one request per transfer: action (reserve or release) and an
//   inclusive start/end slot range. rsp_o returns exactly one result per request:
//   status (done, invalid range, slot occupied) and price, the slot count times
//   the price_per_slot register, nonzero only for a successful reserve.
//   the price register sits at byte address 0 of the apb port.
//   the bitmap is one word of 64 slots per ram entry; the ram is read one word per
//   cycle, each word written back in the cycle after its read.
//   order of work, n = words spanned by the range:
//     invalid range            refused without ram access
//     release                  one read-modify-write pass over the n words
//     reserve, no conflict     check pass, then read-modify-write pass, then price
//     reserve, conflict        check pass stops at the first occupied word, no write
//   one request is in work at a time; the next is taken once the result sits in the
//   output register, even while the receiver stalls it. a second result waits until
//   the output register is free.
//   after reset a clearing pass over all NUM_WORDS words (64) zeroes the bitmap; no
//   request is taken during it, register writes are.

module slot_bitmap_range_reserver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  sbr_req_if.sink                     req_i,
  sbr_rsp_if.source                   rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sbr_pkg::APB_AW-1:0]  paddr,
  input  logic [sbr_pkg::APB_DW-1:0]  pwdata,
  output logic [sbr_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  logic [sbr_pkg::RATE_W-1:0]     price_per_slot;
  sbr_pkg::ram_req_t              ram_req;
  logic [sbr_pkg::WORD_BITS-1:0]  ram_rdata;

  sbr_cfg u_cfg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .price_per_slot_o (price_per_slot)
  );

  sbr_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req              (req_i),
    .rsp              (rsp_o),
    .price_per_slot_i (price_per_slot),
    .ram_req_o        (ram_req),
    .ram_rdata_i      (ram_rdata)
  );

  sbr_ram #(
    .DEPTH (sbr_pkg::NUM_WORDS),
    .WIDTH (sbr_pkg::WORD_BITS),
    .AW    (sbr_pkg::WORD_AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

endmodule
